// ===== hw/rtl/hgcd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hgcd_pkg: shared types, constants and helpers for the great-circle block
// Fixed-point formats, the arctangent table and the angle folding helpers.
// ----------------------------------------------------------------------------
package hgcd_pkg;

	// angle units of the input coordinates
	localparam int ANGLE_FRAC_BITS = 22;
	localparam int CORDIC_STAGES_DEF = 24;

	// sine, cosine and products in Q30; CORDIC angles in Q32 radians
	typedef logic signed [33:0] xy_t;
	typedef logic signed [34:0] ang_t;
	typedef logic [29:0] turn_t;

	// square root datapath
	localparam int ROOT_W = 31;
	typedef logic [ROOT_W-1:0] root_t;
	typedef logic [2*ROOT_W-1:0] rad_t;
	typedef logic [ROOT_W+2:0] rem_t;

	localparam logic [31:0] FULL_TURN = 32'(360) << ANGLE_FRAC_BITS;
	localparam logic [31:0] HALF_TURN = 32'(180) << ANGLE_FRAC_BITS;
	localparam logic [31:0] QUARTER_TURN = 32'(90) << ANGLE_FRAC_BITS;

	// pi/180 in Q36, and the CORDIC start value (inverse gain) in Q30
	localparam logic [30:0] DEG2RAD_Q36 = 31'd1199381129;
	localparam xy_t GAIN_Q30 = 34'sd652032874;
	localparam logic [30:0] Q_ONE = 31'd1073741824;
	localparam logic [22:0] DIST_MAX = 23'd8388607;

	localparam logic [12:0] RADIUS_RST = 13'd6371;
	localparam logic [15:0] TOL_RST = 16'd4;

	// configuration register indexes
	localparam logic REG_RADIUS = 1'b0;
	localparam logic REG_TOL = 1'b1;

	// atan(2^-i) in Q32, rounded to nearest; at i = 33 the half unit rounds up
	function automatic ang_t atan_q32(input int i);
		ang_t r;
		case (i)
			0: r = 35'sd3373259426;
			1: r = 35'sd1991351318;
			2: r = 35'sd1052175346;
			3: r = 35'sd534100635;
			4: r = 35'sd268086748;
			5: r = 35'sd134174063;
			6: r = 35'sd67103403;
			7: r = 35'sd33553749;
			8: r = 35'sd16777131;
			9: r = 35'sd8388597;
			10: r = 35'sd4194303;
			default: r = (i <= 32) ? ang_t'(64'(1) << (32 - i)) :
				((i == 33) ? ang_t'(1) : '0);
		endcase
		return r;
	endfunction

	// reduce a magnitude modulo one turn and fold it into [0, half turn]
	function automatic turn_t fold_turn(input logic [31:0] u);
		logic [31:0] m;
		m = (u >= FULL_TURN) ? u - FULL_TURN : u;
		if (m > HALF_TURN) m = FULL_TURN - m;
		return m[29:0];
	endfunction

	// Q30 product with round to nearest
	function automatic xy_t mulq(input xy_t a, input xy_t b);
		logic signed [67:0] p;
		p = 68'(a) * 68'(b) + (68'sd1 <<< 29);
		return p[63:30];
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/haversine_great_circle_distance.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// haversine_great_circle_distance: fixed-point haversine distance pipeline
// Point pairs in, distance in 1/256 km out, one word per cycle unless stalled.
// ----------------------------------------------------------------------------
// The block takes one point pair every clock cycle unless stalled, and returns
// one distance word per pair, in order. The latency comes from the
// four parallel sine/cosine CORDIC chains, the two 31-cell square-root chains
// and the angle CORDIC chain. The whole pipeline freezes only when a second
// result is waiting in the output skid register behind a stalled word. Write
// the radius and tolerance registers only while no pair is in flight.
// ----------------------------------------------------------------------------
module haversine_great_circle_distance #(
	parameter int CORDIC_STAGES = hgcd_pkg::CORDIC_STAGES_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic signed [29:0] lat_a,
	input  wire logic signed [30:0] lon_a,
	input  wire logic signed [29:0] lat_b,
	input  wire logic signed [30:0] lon_b,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [22:0]             distance,
	output logic                    same_point,
	input  wire logic               wr_en,
	input  wire logic               wr_index,
	input  wire logic [15:0]        wr_data
);
	import hgcd_pkg::*;

	logic [12:0] radius_q;
	logic [15:0] tol_q;
	logic        en, skid_v_q, out_take;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RST;
			tol_q <= TOL_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_RADIUS: radius_q <= wr_data[12:0];
				REG_TOL:    tol_q <= wr_data;
				default:    ;
			endcase
		end
	end

	assign en = !skid_v_q;
	assign in_stall = skid_v_q;

	// stage 1: differences and same-point test
	logic signed [30:0] dlat_c;
	logic signed [31:0] dlon_c;
	logic [31:0] adl_c, ado_c;
	logic vld_s1, same_s1;
	logic signed [29:0] la_s1, lb_s1;
	logic signed [30:0] dlat_s1;
	logic signed [31:0] dlon_s1;

	assign dlat_c = 31'(lat_b) - 31'(lat_a);
	assign dlon_c = 32'(lon_b) - 32'(lon_a);
	assign adl_c = dlat_c[30] ? 32'(-dlat_c) : 32'(dlat_c);
	assign ado_c = dlon_c[31] ? 32'(-dlon_c) : 32'(dlon_c);

	always_ff @(posedge clk) begin
		if (en) begin
			la_s1 <= lat_a;
			lb_s1 <= lat_b;
			dlat_s1 <= dlat_c;
			dlon_s1 <= dlon_c;
			same_s1 <= (adl_c < 32'(tol_q)) && (ado_c < 32'(tol_q));
		end
	end

	// stage 2: magnitudes folded into half a turn
	logic vld_s2, same_s2;
	turn_t ul_s2, uo_s2, ua_s2, ub_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			same_s2 <= same_s1;
			ul_s2 <= fold_turn(dlat_s1[30] ? 32'(-dlat_s1) : 32'(dlat_s1));
			uo_s2 <= fold_turn(dlon_s1[31] ? 32'(-dlon_s1) : 32'(dlon_s1));
			ua_s2 <= fold_turn(la_s1[29] ? -32'(la_s1) : 32'(la_s1));
			ub_s2 <= fold_turn(lb_s1[29] ? -32'(lb_s1) : 32'(lb_s1));
		end
	end

	// stage 3: fold latitudes into a quarter turn, note the cosine sign
	logic vld_s3, same_s3, nega_s3, negb_s3;
	turn_t ul_s3, uo_s3, ua_s3, ub_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			same_s3 <= same_s2;
			ul_s3 <= ul_s2;
			uo_s3 <= uo_s2;
			nega_s3 <= 32'(ua_s2) > QUARTER_TURN;
			negb_s3 <= 32'(ub_s2) > QUARTER_TURN;
			ua_s3 <= (32'(ua_s2) > QUARTER_TURN) ? turn_t'(HALF_TURN - 32'(ua_s2)) : ua_s2;
			ub_s3 <= (32'(ub_s2) > QUARTER_TURN) ? turn_t'(HALF_TURN - 32'(ub_s2)) : ub_s2;
		end
	end

	// stage 4: degrees to Q32 radians, half angles for the differences
	localparam int SH_HALF = ANGLE_FRAC_BITS + 5;
	localparam int SH_WHOLE = ANGLE_FRAC_BITS + 4;
	logic vld_s4, same_s4, nega_s4, negb_s4;
	ang_t zl_s4, zo_s4, za_s4, zb_s4;
	logic [60:0] pl_c, po_c, pa_c, pb_c;

	assign pl_c = 61'(ul_s3) * 61'(DEG2RAD_Q36) + (61'(1) << (SH_HALF - 1));
	assign po_c = 61'(uo_s3) * 61'(DEG2RAD_Q36) + (61'(1) << (SH_HALF - 1));
	assign pa_c = 61'(ua_s3) * 61'(DEG2RAD_Q36) + (61'(1) << (SH_WHOLE - 1));
	assign pb_c = 61'(ub_s3) * 61'(DEG2RAD_Q36) + (61'(1) << (SH_WHOLE - 1));

	always_ff @(posedge clk) begin
		if (en) begin
			same_s4 <= same_s3;
			nega_s4 <= nega_s3;
			negb_s4 <= negb_s3;
			zl_s4 <= ang_t'(pl_c >> SH_HALF);
			zo_s4 <= ang_t'(po_c >> SH_HALF);
			za_s4 <= ang_t'(pa_c >> SH_WHOLE);
			zb_s4 <= ang_t'(pb_c >> SH_WHOLE);
		end
	end

	// valid line through the front stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// sine and cosine chains
	logic vl_r, vo_r, va_r, vb_r;
	logic [2:0] tag_l;
	xy_t yl_r, yo_r, xa_r, xb_r;

	hgcd_cordic_chain #(.STAGES(CORDIC_STAGES), .VECTOR(1'b0), .TAG_W(3)) u_rot_dlat (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_i(vld_s4),
		.tag_i({same_s4, nega_s4, negb_s4}),
		.x_i(GAIN_Q30), .y_i('0), .z_i(zl_s4),
		.vld_o(vl_r), .tag_o(tag_l), .x_o(), .y_o(yl_r), .z_o()
	);
	hgcd_cordic_chain #(.STAGES(CORDIC_STAGES), .VECTOR(1'b0), .TAG_W(1)) u_rot_dlon (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_i(vld_s4), .tag_i(1'b0),
		.x_i(GAIN_Q30), .y_i('0), .z_i(zo_s4),
		.vld_o(vo_r), .tag_o(), .x_o(), .y_o(yo_r), .z_o()
	);
	hgcd_cordic_chain #(.STAGES(CORDIC_STAGES), .VECTOR(1'b0), .TAG_W(1)) u_rot_lata (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_i(vld_s4), .tag_i(1'b0),
		.x_i(GAIN_Q30), .y_i('0), .z_i(za_s4),
		.vld_o(va_r), .tag_o(), .x_o(xa_r), .y_o(), .z_o()
	);
	hgcd_cordic_chain #(.STAGES(CORDIC_STAGES), .VECTOR(1'b0), .TAG_W(1)) u_rot_latb (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_i(vld_s4), .tag_i(1'b0),
		.x_i(GAIN_Q30), .y_i('0), .z_i(zb_s4),
		.vld_o(vb_r), .tag_o(), .x_o(xb_r), .y_o(), .z_o()
	);

	// haversine products over three stages
	xy_t ca_c, cb_c;
	xy_t p1_s5, p2_s5, p3_s5, p1_s6, p4_s6;
	logic signed [34:0] sum_c;
	logic [30:0] a_s7;
	logic vld_s5, vld_s6, vld_s7, same_s5, same_s6, same_s7;

	assign ca_c = tag_l[1] ? -xa_r : xa_r;
	assign cb_c = tag_l[0] ? -xb_r : xb_r;
	assign sum_c = 35'(p1_s6) + 35'(p4_s6);

	always_ff @(posedge clk) begin
		if (en) begin
			same_s5 <= tag_l[2];
			p1_s5 <= mulq(yl_r, yl_r);
			p2_s5 <= mulq(ca_c, cb_c);
			p3_s5 <= mulq(yo_r, yo_r);
			same_s6 <= same_s5;
			p1_s6 <= p1_s5;
			p4_s6 <= mulq(p2_s5, p3_s5);
			same_s7 <= same_s6;
			if (sum_c[34]) begin
				a_s7 <= '0;
			end else if (sum_c > 35'(Q_ONE)) begin
				a_s7 <= Q_ONE;
			end else begin
				a_s7 <= sum_c[30:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s5 <= vl_r;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	// square roots of a and of one minus a
	logic vs_r, vq_r, same_r;
	root_t s_r, q_r;
	logic [30:0] na_c;

	assign na_c = Q_ONE - a_s7;

	hgcd_sqrt_chain #(.TAG_W(1)) u_sqrt_a (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_i(vld_s7), .tag_i(same_s7),
		.rad_i({a_s7, 31'b0} >> 1), .vld_o(vs_r), .tag_o(same_r), .root_o(s_r)
	);
	hgcd_sqrt_chain #(.TAG_W(1)) u_sqrt_na (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_i(vld_s7), .tag_i(1'b0),
		.rad_i({na_c, 31'b0} >> 1), .vld_o(vq_r), .tag_o(), .root_o(q_r)
	);

	// half central angle by vectoring
	logic vv_r;
	logic [1:0] tag_v;
	ang_t zv_r;

	hgcd_cordic_chain #(.STAGES(CORDIC_STAGES), .VECTOR(1'b1), .TAG_W(2)) u_vec (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_i(vs_r),
		.tag_i({same_r, s_r == '0}),
		.x_i(xy_t'({3'b0, q_r})), .y_i(xy_t'({3'b0, s_r})), .z_i('0),
		.vld_o(vv_r), .tag_o(tag_v), .x_o(), .y_o(), .z_o(zv_r)
	);

	// scale by the radius
	logic [46:0] prod_s8;
	logic vld_s8, same_s8, szero_s8;
	logic [33:0] zc_c;

	assign zc_c = zv_r[34] ? '0 : zv_r[33:0];

	always_ff @(posedge clk) begin
		if (en) begin
			same_s8 <= tag_v[1];
			szero_s8 <= tag_v[0];
			prod_s8 <= 47'(radius_q) * 47'(zc_c);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
		end else if (en) begin
			vld_s8 <= vv_r;
		end
	end

	// round, clamp and pick the final word
	logic [46:0] rnd_c;
	logic [23:0] sh_c;
	logic [22:0] dist_c;
	logic        arrive;

	assign rnd_c = prod_s8 + (47'(1) << 22);
	assign sh_c = rnd_c[46:23];
	always_comb begin
		if (same_s8 || szero_s8) begin
			dist_c = '0;
		end else if (sh_c > 24'(DIST_MAX)) begin
			dist_c = DIST_MAX;
		end else begin
			dist_c = sh_c[22:0];
		end
	end

	assign arrive = en && vld_s8;
	assign out_take = out_valid && !out_stall;

	// output register with one skid entry
	logic [22:0] skid_dist_q;
	logic        skid_same_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (out_take) skid_v_q <= 1'b0;
		end else if (!out_valid || out_take) begin
			out_valid <= arrive;
		end else if (arrive) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (out_take) begin
				distance <= skid_dist_q;
				same_point <= skid_same_q;
			end
		end else if (!out_valid || out_take) begin
			if (arrive) begin
				distance <= dist_c;
				same_point <= same_s8;
			end
		end else if (arrive) begin
			skid_dist_q <= dist_c;
			skid_same_q <= same_s8;
		end
	end

	// checks
	a_same_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && same_point |-> distance == '0)
		else $error("same point word with nonzero distance");
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_valid)
		else $error("skid entry without an output word");
	a_skid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q && !out_take |=> skid_v_q)
		else $error("skid entry dropped while output stalled");
	a_chains_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		vl_r == vo_r && vl_r == va_r && vl_r == vb_r && vs_r == vq_r)
		else $error("parallel chains out of step");
endmodule
`default_nettype wire

// ===== hw/rtl/hgcd_cordic_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hgcd_cordic_cell: one CORDIC micro-rotation
// Rotation mode steers on the angle residue, vectoring mode on the sign of y.
// ----------------------------------------------------------------------------
module hgcd_cordic_cell #(
	parameter int SHIFT = 0,
	parameter bit VECTOR = 1'b0
) (
	input  wire logic         clk,
	input  wire logic         en,
	input  wire hgcd_pkg::xy_t  x_i,
	input  wire hgcd_pkg::xy_t  y_i,
	input  wire hgcd_pkg::ang_t z_i,
	output hgcd_pkg::xy_t       x_o,
	output hgcd_pkg::xy_t       y_o,
	output hgcd_pkg::ang_t      z_o
);
	import hgcd_pkg::*;

	localparam ang_t STEP = atan_q32(SHIFT);

	xy_t  dx, dy;
	logic turn_up;
	xy_t  x_s1, y_s1;
	ang_t z_s1;

	assign dx = y_i >>> SHIFT;
	assign dy = x_i >>> SHIFT;
	assign turn_up = VECTOR ? !y_i[33] : z_i[34];

	// rotate one step toward the target
	always_ff @(posedge clk) begin
		if (en) begin
			if (turn_up) begin
				x_s1 <= x_i + dx;
				y_s1 <= y_i - dy;
				z_s1 <= z_i + STEP;
			end else begin
				x_s1 <= x_i - dx;
				y_s1 <= y_i + dy;
				z_s1 <= z_i - STEP;
			end
		end
	end

	assign x_o = x_s1;
	assign y_o = y_s1;
	assign z_o = z_s1;
endmodule
`default_nettype wire

// ===== hw/rtl/hgcd_cordic_chain.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hgcd_cordic_chain: unrolled CORDIC, one cell per stage
// Carries a valid bit and a side tag in step with the datapath.
// ----------------------------------------------------------------------------
module hgcd_cordic_chain #(
	parameter int STAGES = 24,
	parameter bit VECTOR = 1'b0,
	parameter int TAG_W = 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire logic             vld_i,
	input  wire logic [TAG_W-1:0] tag_i,
	input  wire hgcd_pkg::xy_t      x_i,
	input  wire hgcd_pkg::xy_t      y_i,
	input  wire hgcd_pkg::ang_t     z_i,
	output logic                  vld_o,
	output logic [TAG_W-1:0]      tag_o,
	output hgcd_pkg::xy_t           x_o,
	output hgcd_pkg::xy_t           y_o,
	output hgcd_pkg::ang_t          z_o
);
	import hgcd_pkg::*;

	xy_t  x_c [0:STAGES];
	xy_t  y_c [0:STAGES];
	ang_t z_c [0:STAGES];
	logic [STAGES-1:0] vld_q;
	logic [TAG_W-1:0]  tag_q [0:STAGES-1];

	assign x_c[0] = x_i;
	assign y_c[0] = y_i;
	assign z_c[0] = z_i;

	for (genvar i = 0; i < STAGES; i++) begin : g_cell
		hgcd_cordic_cell #(.SHIFT(i), .VECTOR(VECTOR)) u_cell (
			.clk(clk), .en(en),
			.x_i(x_c[i]), .y_i(y_c[i]), .z_i(z_c[i]),
			.x_o(x_c[i+1]), .y_o(y_c[i+1]), .z_o(z_c[i+1])
		);
	end

	// advance valid bits alongside the cells
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[STAGES-2:0], vld_i};
		end
	end

	// advance the side tag
	always_ff @(posedge clk) begin
		if (en) begin
			tag_q[0] <= tag_i;
			for (int k = 1; k < STAGES; k++) tag_q[k] <= tag_q[k-1];
		end
	end

	assign vld_o = vld_q[STAGES-1];
	assign tag_o = tag_q[STAGES-1];
	assign x_o = x_c[STAGES];
	assign y_o = y_c[STAGES];
	assign z_o = z_c[STAGES];
endmodule
`default_nettype wire

// ===== hw/rtl/hgcd_sqrt_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hgcd_sqrt_cell: one digit of a restoring integer square root
// Brings down two radicand bits and decides one root bit.
// ----------------------------------------------------------------------------
module hgcd_sqrt_cell (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire hgcd_pkg::rem_t  rem_i,
	input  wire hgcd_pkg::root_t root_i,
	input  wire hgcd_pkg::rad_t  rad_i,
	output hgcd_pkg::rem_t       rem_o,
	output hgcd_pkg::root_t      root_o,
	output hgcd_pkg::rad_t       rad_o
);
	import hgcd_pkg::*;

	rem_t  cur, trial;
	rem_t  rem_s1;
	root_t root_s1;
	rad_t  rad_s1;

	assign cur = {rem_i[ROOT_W:0], rad_i[2*ROOT_W-1 -: 2]};
	assign trial = {1'b0, root_i, 2'b01};

	// subtract the trial value when it fits
	always_ff @(posedge clk) begin
		if (en) begin
			if (cur >= trial) begin
				rem_s1 <= cur - trial;
				root_s1 <= {root_i[ROOT_W-2:0], 1'b1};
			end else begin
				rem_s1 <= cur;
				root_s1 <= {root_i[ROOT_W-2:0], 1'b0};
			end
			rad_s1 <= rad_i << 2;
		end
	end

	assign rem_o = rem_s1;
	assign root_o = root_s1;
	assign rad_o = rad_s1;
endmodule
`default_nettype wire

// ===== hw/rtl/hgcd_sqrt_chain.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hgcd_sqrt_chain: pipelined floor square root, one cell per root bit
// Carries a valid bit and a side tag in step with the datapath.
// ----------------------------------------------------------------------------
module hgcd_sqrt_chain #(
	parameter int TAG_W = 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire logic             vld_i,
	input  wire logic [TAG_W-1:0] tag_i,
	input  wire hgcd_pkg::rad_t     rad_i,
	output logic                  vld_o,
	output logic [TAG_W-1:0]      tag_o,
	output hgcd_pkg::root_t         root_o
);
	import hgcd_pkg::*;

	rem_t  rem_c  [0:ROOT_W];
	root_t root_c [0:ROOT_W];
	rad_t  rad_c  [0:ROOT_W];
	logic [ROOT_W-1:0] vld_q;
	logic [TAG_W-1:0]  tag_q [0:ROOT_W-1];

	assign rem_c[0] = '0;
	assign root_c[0] = '0;
	assign rad_c[0] = rad_i;

	for (genvar i = 0; i < ROOT_W; i++) begin : g_cell
		hgcd_sqrt_cell u_cell (
			.clk(clk), .en(en),
			.rem_i(rem_c[i]), .root_i(root_c[i]), .rad_i(rad_c[i]),
			.rem_o(rem_c[i+1]), .root_o(root_c[i+1]), .rad_o(rad_c[i+1])
		);
	end

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[ROOT_W-2:0], vld_i};
		end
	end

	// advance the side tag
	always_ff @(posedge clk) begin
		if (en) begin
			tag_q[0] <= tag_i;
			for (int k = 1; k < ROOT_W; k++) tag_q[k] <= tag_q[k-1];
		end
	end

	assign vld_o = vld_q[ROOT_W-1];
	assign tag_o = tag_q[ROOT_W-1];
	assign root_o = root_c[ROOT_W];
endmodule
`default_nettype wire

// ===== tb/haversine_great_circle_distance_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// haversine_great_circle_distance_chk: distance predictor and output checker
// Watches the point-pair and distance channels and the register port. For each
// accepted pair it computes the distance bit for bit and queues it. Each
// accepted result word is compared with the oldest queued distance.
// ----------------------------------------------------------------------------
module haversine_great_circle_distance_chk (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic signed [29:0] lat_a,
	input  logic signed [30:0] lon_a,
	input  logic signed [29:0] lat_b,
	input  logic signed [30:0] lon_b,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [22:0]        distance,
	input  logic               same_point,
	input  logic               wr_en,
	input  logic               wr_index,
	input  logic [15:0]        wr_data,
	output int                 fails,
	output int                 pending
);
	import hgcd_pkg::*;

	typedef struct packed {
		logic [22:0] span;
		logic        same;
	} dist_word_t;

	localparam int STAGES = 24;
	localparam int FRAC = 22;
	localparam longint unsigned TURN = 64'd360 << FRAC;
	localparam longint unsigned HALF = 64'd180 << FRAC;
	localparam longint unsigned QUART = 64'd90 << FRAC;
	localparam longint ONE_Q30 = 64'sd1 << 30;

	longint atan_rom [STAGES];
	longint unsigned deg_to_rad;
	logic [12:0] radius;
	logic [15:0] tolerance;
	dist_word_t expected_dist [$];

	// atan(1/n) in Q62 by the alternating series
	function automatic longint unsigned atan_inv_q62(input longint unsigned n);
		longint unsigned p, sum, term, k;
		p = (64'd1 << 62) / n;
		sum = 0;
		k = 0;
		while (p != 0) begin
			term = p / (2 * k + 1);
			if (k[0]) sum = sum - term;
			else sum = sum + term;
			p = p / n / n;
			k++;
		end
		return sum;
	endfunction

	function automatic longint mul_q30(input longint a, input longint b);
		return (a * b + (64'sd1 <<< 29)) >>> 30;
	endfunction

	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic longint rad_q32(input longint unsigned u, input int sh);
		return longint'((u * deg_to_rad + (64'd1 << (sh - 1))) >> sh);
	endfunction

	function automatic longint unsigned fold_half(input longint d);
		longint unsigned u;
		u = (d < 0) ? longint'(-d) : d;
		u = u % TURN;
		if (u > HALF) u = TURN - u;
		return u;
	endfunction

	// rotation mode: returns cosine and sine in Q30
	function automatic void rotate(input longint z, output longint c, output longint s);
		longint x, y, dx, dy;
		x = 64'sd652032874;
		y = 0;
		for (int i = 0; i < STAGES; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x = x - dx; y = y + dy; z = z - atan_rom[i];
			end else begin
				x = x + dx; y = y - dy; z = z + atan_rom[i];
			end
		end
		c = x;
		s = y;
	endfunction

	// vectoring mode: returns the angle of (x, y) in Q32
	function automatic longint vec_angle(input longint x, input longint y);
		longint z, dx, dy;
		z = 0;
		for (int i = 0; i < STAGES; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x = x + dx; y = y - dy; z = z + atan_rom[i];
			end else begin
				x = x - dx; y = y + dy; z = z - atan_rom[i];
			end
		end
		return z;
	endfunction

	function automatic longint sin_of_half(input longint d);
		longint c, s;
		rotate(rad_q32(fold_half(d), FRAC + 5), c, s);
		return s;
	endfunction

	function automatic longint cos_of_lat(input longint lat);
		longint c, s;
		longint unsigned u;
		logic flip;
		u = fold_half(lat);
		flip = u > QUART;
		if (flip) u = HALF - u;
		rotate(rad_q32(u, FRAC + 4), c, s);
		return flip ? -c : c;
	endfunction

	function automatic dist_word_t haversine(input longint la, input longint loa,
			input longint lb, input longint lob);
		dist_word_t w;
		longint dlat, dlon, sl, so, ca, cb, a, z;
		longint unsigned adl, ado, s, q, d;
		dlat = lb - la;
		dlon = lob - loa;
		adl = (dlat < 0) ? -dlat : dlat;
		ado = (dlon < 0) ? -dlon : dlon;
		w = '0;
		if (adl < tolerance && ado < tolerance) begin
			w.same = 1'b1;
			return w;
		end
		sl = sin_of_half(dlat);
		so = sin_of_half(dlon);
		ca = cos_of_lat(la);
		cb = cos_of_lat(lb);
		a = mul_q30(sl, sl) + mul_q30(mul_q30(ca, cb), mul_q30(so, so));
		if (a < 0) a = 0;
		if (a > ONE_Q30) a = ONE_Q30;
		s = int_sqrt(longint'(a) << 30);
		q = int_sqrt(longint'(ONE_Q30 - a) << 30);
		if (s == 0) begin
			d = 0;
		end else begin
			z = vec_angle(longint'(q), longint'(s));
			if (z < 0) z = 0;
			d = (64'(radius) * longint'(z) + (64'd1 << 22)) >> 23;
			if (d > 64'd8388607) d = 64'd8388607;
		end
		w.span = d[22:0];
		return w;
	endfunction

	task automatic report(input string what, input longint got, input longint want);
		$display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
		fails++;
	endtask

	// build the arctangent table and degree constant
	initial begin
		longint unsigned qpi;
		fails = 0;
		qpi = atan_inv_q62(2) + atan_inv_q62(3);
		for (int i = 0; i < STAGES; i++) begin
			atan_rom[i] = longint'((((i == 0) ? qpi : atan_inv_q62(64'd1 << i))
				+ (64'd1 << 29)) >> 30);
		end
		deg_to_rad = (qpi / 45 + (64'd1 << 25)) >> 26;
	end

	assign pending = expected_dist.size();

	// track the registers
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius <= 13'd6371;
			tolerance <= 16'd4;
		end else if (wr_en) begin
			if (wr_index == REG_RADIUS) radius <= wr_data[12:0];
			else tolerance <= wr_data;
		end
	end

	// predict on each accepted pair, compare on each accepted word
	always @(posedge clk) begin
		dist_word_t w;
		if (arst_n) begin
			if (in_valid && !in_stall)
				expected_dist.push_back(haversine(lat_a, lon_a, lat_b, lon_b));
			if (out_valid && !out_stall) begin
				if (expected_dist.size() == 0) begin
					report("unexpected word, distance", distance, -1);
				end else begin
					w = expected_dist.pop_front();
					if (distance !== w.span) report("distance", distance, w.span);
					if (same_point !== w.same) report("same_point", same_point, w.same);
				end
			end
		end
	end
endmodule

// ===== tb/haversine_great_circle_distance_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// haversine_great_circle_distance_tb: top of the distance testbench
// Drives directed and random point pairs through several radius and tolerance
// settings with random idling on both channels, and gives the verdict.
// ----------------------------------------------------------------------------
module haversine_great_circle_distance_tb;
	import hgcd_pkg::*;

	localparam int LAT_MAX = 377487360;
	localparam int LON_MAX = 754974720;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [29:0] lat_a = '0;
	logic signed [30:0] lon_a = '0;
	logic signed [29:0] lat_b = '0;
	logic signed [30:0] lon_b = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [22:0] distance;
	logic same_point;
	logic wr_en = 1'b0;
	logic wr_index = REG_RADIUS;
	logic [15:0] wr_data = '0;
	logic calm = 1'b0;
	int fails, pending;

	always #6 clk = ~clk;

	haversine_great_circle_distance u_dut (.*);
	haversine_great_circle_distance_chk u_chk (.*);

	// stall the result side at random unless in a calm stretch
	always @(posedge clk) begin
		out_stall <= !calm && ($urandom_range(0, 99) < 11);
	end

	// present one pair and hold it until accepted
	task automatic send_pair(input int la, input int loa, input int lb, input int lob);
		while (!calm && $urandom_range(0, 99) < 11) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		lat_a <= 30'(la); lon_a <= 31'(loa); lat_b <= 30'(lb); lon_b <= 31'(lob);
		do @(posedge clk); while (in_stall);
	endtask

	// drain the pipeline, then write a register
	task automatic write_reg(input logic idx, input logic [15:0] val);
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (120) @(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	function automatic int in_lat();
		return int'($urandom_range(0, 2 * LAT_MAX)) - LAT_MAX;
	endfunction

	function automatic int in_lon();
		return int'($urandom_range(0, 2 * LON_MAX)) - LON_MAX;
	endfunction

	task automatic random_pairs(input int count, input int tol);
		int la, loa, lb, lob, k;
		for (int n = 0; n < count; n++) begin
			calm <= (n >= count / 3) && (n < count / 2);
			k = $urandom_range(0, 9);
			la = in_lat(); loa = in_lon(); lb = in_lat(); lob = in_lon();
			if (k == 6) begin
				// raw bits, out of the geographic range too
				la = $urandom; loa = $urandom; lb = $urandom; lob = $urandom;
			end else if (k == 7) begin
				// nearly the same point, around the tolerance
				lb = la + $urandom_range(0, 2 * tol + 2) - tol - 1;
				lob = loa + $urandom_range(0, 2 * tol + 2) - tol - 1;
			end else if (k == 8) begin
				// short hop
				lb = la + $urandom_range(0, 2000) - 1000;
				lob = loa + $urandom_range(0, 200000) - 100000;
			end else if (k == 9) begin
				// near antipode
				lb = -la + $urandom_range(0, 100) - 50;
				lob = (loa > 0) ? loa - LON_MAX : loa + LON_MAX;
			end
			send_pair(la, loa, lb, lob);
		end
		calm <= 1'b0;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed pairs at reset settings
		send_pair(0, 0, 0, 0);
		send_pair(0, 0, 3, -3);
		send_pair(0, 0, 4, 0);
		send_pair(0, 0, 0, -4);
		send_pair(-LAT_MAX, -LON_MAX, LAT_MAX, LON_MAX);
		send_pair(LAT_MAX, 0, -LAT_MAX, 0);
		send_pair(0, 0, 0, LON_MAX);
		send_pair(0, -LON_MAX, 0, LON_MAX);
		send_pair(LAT_MAX, 5, LAT_MAX, -LON_MAX);
		send_pair(30'sh1FFFFFFF, 31'sh3FFFFFFF, 30'sh20000000, 31'sh40000000);
		send_pair(30'sh20000000, 31'sh40000000, 30'sh20000000, 31'sh3FFFFFFF);
		send_pair(30'sh1FFFFFFF, 0, 30'sh1FFFFFFF, 1000);
		send_pair(-30'sd1, -31'sd1, 30'sd1, 31'sd1);
		send_pair(12345678, -98765432, -87654321, 23456789);
		send_pair(0, 0, 1, 100);
		random_pairs(250, 4);

		write_reg(REG_RADIUS, 16'h1FFF);
		write_reg(REG_TOL, 16'hFFFF);
		send_pair(0, 0, 65534, -65534);
		send_pair(0, 0, 65535, 0);
		send_pair(LAT_MAX, 0, -LAT_MAX, 0);
		random_pairs(250, 65535);

		write_reg(REG_RADIUS, 16'hE001);
		write_reg(REG_TOL, 16'h0000);
		send_pair(0, 0, 0, 0);
		send_pair(-LAT_MAX, LON_MAX, LAT_MAX, -LON_MAX);
		random_pairs(250, 2);

		write_reg(REG_RADIUS, 16'h0000);
		write_reg(REG_TOL, 16'd100);
		random_pairs(60, 100);

		write_reg(REG_RADIUS, 16'd3959);
		write_reg(REG_TOL, 16'd4000);
		random_pairs(200, 4000);

		// drain and close
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (150) @(posedge clk);
		if (fails == 0) $display("*** PASSED ***");
		else $display("*** FAILED ***");
		$finish;
	end

	// end a hung run
	initial begin
		#(12 * 600000);
		$display("*** FAILED ***");
		$finish;
	end
endmodule
